>>> src/cts_pkg.sv
// Shared types and codes for the cosine top-k vector search core.
// Used by the stream interfaces and by the core; depends on nothing.
package cts_pkg;

  localparam int TOPK_W = 5;

  localparam logic ACTION_STORE = 1'b0;
  localparam logic ACTION_QUERY = 1'b1;

  localparam logic [1:0] STATUS_STORED = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_EMPTY  = 2'd2;
  localparam logic [1:0] STATUS_MATCH  = 2'd3;

  localparam logic REG_TOP_K = 1'b0;

  typedef struct packed {
    logic               action;
    logic [15:0]        key;
    logic signed [15:0] elem_value;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         slot;
    logic [15:0]        match_key;
    logic signed [15:0] score;
    logic               end_of_results;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KRD,
    ST_KCMP,
    ST_COPY,
    ST_MAC,
    ST_CHK,
    ST_MUL,
    ST_SQRT,
    ST_DIV,
    ST_RANK,
    ST_MIN,
    ST_EMIT
  } state_t;

endpackage

>>> src/cts_in_if.sv
// Input word channel of the vector search core.
// Depends on cts_pkg for the word type.
interface cts_in_if;
  logic              valid;
  logic              ready;
  cts_pkg::in_word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> src/cts_out_if.sv
// Result word channel of the vector search core.
// Depends on cts_pkg for the word type.
interface cts_out_if;
  logic               valid;
  logic               ready;
  cts_pkg::out_word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> src/cosine_top_k_vector_search_core.sv
// Cosine-similarity top-k vector search core: sequencer, memories and one shared
// multiply / square-root / divide datapath. Depends on cts_pkg, cts_in_if, cts_out_if.
//
// Usage: words on req carry one vector element each (action, key, elem_value, last).
// Elements collect in a staging buffer; the word marked last commits the vector
// (store) or scores it against every table entry (query). Store answers with one
// word (stored or table full); a query answers with top_k match words, clamped to
// MAX_TOP_K and to the entry count, in slot order, or one table-empty word.
// top_k is written over the APB port at byte 0. A store scans the key table for
// its key and, if found or if there is room, copies the staging buffer into that
// row of the vector memory one element at a time. A query works each entry in
// turn: multiply-accumulate, a norm check, shift-add product, square root,
// restoring division and a rank step, plus a minimum scan over the kept slots once
// the list is full; then it emits the result words. req.ready is low while a
// vector is worked.
// Reset clears the entry count, element position and top_k (back to 1); tables
// need no clearing. A stalled receiver holds the result register and the
// sequencer waits on it; nothing is dropped.
module cosine_top_k_vector_search_core #(
  parameter int VECTOR_DIM    = 64,
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_TOP_K     = 16
) (
  input  logic        clk,
  input  logic        rst,
  cts_in_if.sink      req,
  cts_out_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW_E  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int SA_W  = $clog2(VECTOR_DIM);
  localparam int POS_W = $clog2(VECTOR_DIM + 1);
  localparam int VA_W  = $clog2(TABLE_ENTRIES * VECTOR_DIM);
  localparam int ACC_W = 32 + $clog2(VECTOR_DIM);
  localparam int P_W   = 2 * ACC_W;
  localparam int NUM_W = ACC_W + 15;
  localparam int SC_W  = $clog2(NUM_W + 1);
  localparam int K_W   = $clog2(MAX_TOP_K + 1);
  localparam int KI_W  = (MAX_TOP_K > 1) ? $clog2(MAX_TOP_K) : 1;

  cts_pkg::state_t state, state_next;

  logic [cts_pkg::TOPK_W-1:0] top_k;
  logic [POS_W-1:0]   pos;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   ent;
  logic [VA_W-1:0]    base;
  logic [POS_W-1:0]   ci;
  logic [SA_W-1:0]    ci_d;
  logic [15:0]        skey;
  logic [1:0]         res_status;
  logic               single;

  logic signed [15:0] stg [VECTOR_DIM];
  logic signed [15:0] stg_q;
  logic signed [15:0] vs [TABLE_ENTRIES * VECTOR_DIM];
  logic signed [15:0] vs_q;
  logic [15:0]        kt [TABLE_ENTRIES];
  logic [15:0]        key_q;

  logic signed [ACC_W-1:0] dot;
  logic [ACC_W-1:0]   na;
  logic [ACC_W-1:0]   nb;
  logic [P_W-1:0]     mcand;
  logic [ACC_W-1:0]   mplier;
  logic [P_W-1:0]     prod;
  logic [ACC_W-1:0]   root;
  logic [ACC_W+1:0]   rem;
  logic [NUM_W-1:0]   num;
  logic [ACC_W:0]     drem;
  logic [NUM_W-1:0]   quo;
  logic               neg;
  logic [SC_W-1:0]    sc;

  logic [K_W-1:0]     kq;
  logic [K_W-1:0]     kq_calc;
  logic signed [15:0] best_s [MAX_TOP_K];
  logic [15:0]        best_k [MAX_TOP_K];
  logic [K_W-1:0]     mj;
  logic signed [15:0] min_v;
  logic [KI_W-1:0]    min_i;
  logic [K_W-1:0]     oi;

  logic               in_fire;
  logic               emit_fire;
  logic               stg_we;
  logic               vs_we;
  logic               kt_we;
  logic               append;
  logic               more_entries;
  logic               emit_done;
  logic               mac_on;
  logic               elem_ok;

  logic signed [15:0] a_el;
  logic signed [15:0] b_el;
  logic signed [31:0] ab;
  logic signed [31:0] aa;
  logic signed [31:0] bb;
  logic [ACC_W+1:0]   rem_sh;
  logic [ACC_W+1:0]   trial;
  logic [ACC_W:0]     drem_sh;
  logic [ACC_W-1:0]   abs_dot;
  logic signed [15:0] score;
  logic [15:0]        neg_q;
  logic signed [15:0] cur_s;
  logic signed [15:0] min_now_v;
  logic [KI_W-1:0]    min_now_i;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == cts_pkg::REG_TOP_K) ? {27'd0, top_k} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_k <= cts_pkg::TOPK_W'(1);
    end else if (psel && penable && pwrite && paddr[2] == cts_pkg::REG_TOP_K) begin
      top_k <= pwdata[cts_pkg::TOPK_W-1:0];
    end
  end

  // top_k clamped to [1, MAX_TOP_K] and to the entry count
  always_comb begin
    int tk;
    tk = int'(top_k);
    if (tk == 0) tk = 1;
    if (tk > MAX_TOP_K) tk = MAX_TOP_K;
    if (tk > int'(count)) tk = int'(count);
    kq_calc = K_W'(tk);
  end

  // datapath helpers
  assign elem_ok = (ci <= pos);
  assign a_el    = elem_ok ? stg_q : 16'sd0;
  assign b_el    = vs_q;
  assign ab      = a_el * b_el;
  assign aa      = a_el * a_el;
  assign bb      = b_el * b_el;
  assign rem_sh  = {rem[ACC_W-1:0], prod[P_W-1:P_W-2]};
  assign trial   = {root, 2'b01};
  assign drem_sh = {drem[ACC_W-1:0], num[NUM_W-1]};
  assign abs_dot = dot[ACC_W-1] ? ACC_W'(-dot) : ACC_W'(dot);
  assign neg_q   = ~quo[15:0] + 16'd1;

  always_comb begin
    if (!neg) begin
      score = (quo > NUM_W'(32767)) ? 16'sh7fff : signed'(quo[15:0]);
    end else begin
      score = (quo > NUM_W'(32768)) ? 16'sh8000 : signed'(neg_q);
    end
  end

  // running minimum over the kept slots, first found wins ties
  assign cur_s = best_s[KI_W'(mj)];
  always_comb begin
    if (mj == '0 || cur_s < min_v) begin
      min_now_v = cur_s;
      min_now_i = KI_W'(mj);
    end else begin
      min_now_v = min_v;
      min_now_i = min_i;
    end
  end

  assign more_entries = (CNT_W'(ent + 1'b1) < count) && (ent + 1'b1 != '0);
  assign append = (ent >= count) && (count < CNT_W'(TABLE_ENTRIES));
  assign emit_done = single || (oi == kq - 1'b1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cts_pkg::ST_IDLE: begin
        if (in_fire && req.data.last) begin
          if (req.data.action == cts_pkg::ACTION_STORE) state_next = cts_pkg::ST_KRD;
          else if (count == '0) state_next = cts_pkg::ST_EMIT;
          else state_next = cts_pkg::ST_MAC;
        end
      end
      cts_pkg::ST_KRD: begin
        if (ent < count) state_next = cts_pkg::ST_KCMP;
        else if (append) state_next = cts_pkg::ST_COPY;
        else state_next = cts_pkg::ST_EMIT;
      end
      cts_pkg::ST_KCMP: begin
        state_next = (key_q == skey) ? cts_pkg::ST_COPY : cts_pkg::ST_KRD;
      end
      cts_pkg::ST_COPY: begin
        if (ci == POS_W'(VECTOR_DIM)) state_next = cts_pkg::ST_EMIT;
      end
      cts_pkg::ST_MAC: begin
        if (ci == POS_W'(VECTOR_DIM)) state_next = cts_pkg::ST_CHK;
      end
      cts_pkg::ST_CHK: begin
        state_next = (na == '0 || nb == '0) ? cts_pkg::ST_RANK : cts_pkg::ST_MUL;
      end
      cts_pkg::ST_MUL: begin
        if (sc == SC_W'(ACC_W - 1)) state_next = cts_pkg::ST_SQRT;
      end
      cts_pkg::ST_SQRT: begin
        if (sc == SC_W'(ACC_W - 1)) state_next = cts_pkg::ST_DIV;
      end
      cts_pkg::ST_DIV: begin
        if (sc == SC_W'(NUM_W - 1)) state_next = cts_pkg::ST_RANK;
      end
      cts_pkg::ST_RANK: begin
        if (ent < CNT_W'(kq)) begin
          state_next = more_entries ? cts_pkg::ST_MAC : cts_pkg::ST_EMIT;
        end else begin
          state_next = cts_pkg::ST_MIN;
        end
      end
      cts_pkg::ST_MIN: begin
        if (mj == kq - 1'b1) state_next = more_entries ? cts_pkg::ST_MAC : cts_pkg::ST_EMIT;
      end
      cts_pkg::ST_EMIT: begin
        if (emit_fire && emit_done) state_next = cts_pkg::ST_IDLE;
      end
      default: state_next = cts_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req.ready = (state == cts_pkg::ST_IDLE);
    in_fire   = req.valid && req.ready;
    emit_fire = (state == cts_pkg::ST_EMIT) && (!rsp.valid || rsp.ready);
    stg_we    = in_fire && (pos < POS_W'(VECTOR_DIM));
    vs_we     = (state == cts_pkg::ST_COPY) && (ci != '0);
    kt_we     = (state == cts_pkg::ST_KRD) && append;
    mac_on    = (state == cts_pkg::ST_MAC) && (ci != '0);
  end

  // memories
  always_ff @(posedge clk) begin
    if (stg_we) stg[pos[SA_W-1:0]] <= req.data.elem_value;
    stg_q <= stg[ci[SA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (vs_we) vs[base + VA_W'(ci_d)] <= elem_ok ? stg_q : 16'sd0;
    vs_q <= vs[base + VA_W'(ci[SA_W-1:0])];
  end

  always_ff @(posedge clk) begin
    if (kt_we) kt[count[AW_E-1:0]] <= skey;
    key_q <= kt[ent[AW_E-1:0]];
  end

  // sequencer registers and shared datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cts_pkg::ST_IDLE;
      pos   <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      if (stg_we) pos <= pos + 1'b1;
      if (state == cts_pkg::ST_EMIT) pos <= '0;
      if (kt_we) count <= count + 1'b1;
    end

    ci_d <= ci[SA_W-1:0];
    if (mac_on) begin
      dot <= dot + ACC_W'(ab);
      na  <= na + ACC_W'(unsigned'(aa));
      nb  <= nb + ACC_W'(unsigned'(bb));
    end

    case (state)
      cts_pkg::ST_IDLE: begin
        ent  <= '0;
        base <= '0;
        ci   <= '0;
        dot  <= '0;
        na   <= '0;
        nb   <= '0;
        kq   <= kq_calc;
        if (req.data.action == cts_pkg::ACTION_STORE) begin
          skey       <= req.data.key;
          res_status <= cts_pkg::STATUS_STORED;
          single     <= 1'b1;
        end else begin
          skey       <= 16'd0;
          res_status <= cts_pkg::STATUS_EMPTY;
          single     <= (count == '0);
        end
      end
      cts_pkg::ST_KRD: begin
        ci <= '0;
        if (ent >= count && !append) res_status <= cts_pkg::STATUS_FULL;
      end
      cts_pkg::ST_KCMP: begin
        ci <= '0;
        if (key_q != skey) begin
          ent  <= ent + 1'b1;
          base <= base + VA_W'(VECTOR_DIM);
        end
      end
      cts_pkg::ST_COPY, cts_pkg::ST_MAC: begin
        ci <= ci + 1'b1;
      end
      cts_pkg::ST_CHK: begin
        quo    <= '0;
        neg    <= 1'b0;
        mcand  <= P_W'(na);
        mplier <= nb;
        prod   <= '0;
        sc     <= '0;
      end
      cts_pkg::ST_MUL: begin
        if (mplier[0]) prod <= prod + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        sc     <= (sc == SC_W'(ACC_W - 1)) ? '0 : sc + 1'b1;
        if (sc == SC_W'(ACC_W - 1)) begin
          root <= '0;
          rem  <= '0;
        end
      end
      cts_pkg::ST_SQRT: begin
        prod <= prod << 2;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ACC_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ACC_W-2:0], 1'b0};
        end
        sc <= (sc == SC_W'(ACC_W - 1)) ? '0 : sc + 1'b1;
        if (sc == SC_W'(ACC_W - 1)) begin
          num  <= {abs_dot, 15'd0};
          drem <= '0;
          quo  <= '0;
          neg  <= dot[ACC_W-1];
        end
      end
      cts_pkg::ST_DIV: begin
        num <= num << 1;
        if (drem_sh >= {1'b0, root}) begin
          drem <= drem_sh - {1'b0, root};
          quo  <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          drem <= drem_sh;
          quo  <= {quo[NUM_W-2:0], 1'b0};
        end
        sc <= sc + 1'b1;
      end
      cts_pkg::ST_RANK: begin
        mj <= '0;
        if (ent < CNT_W'(kq)) begin
          best_s[KI_W'(ent)] <= score;
          best_k[KI_W'(ent)] <= key_q;
        end
      end
      cts_pkg::ST_MIN: begin
        min_v <= min_now_v;
        min_i <= min_now_i;
        mj    <= mj + 1'b1;
        if (mj == kq - 1'b1 && score > min_now_v) begin
          best_s[min_now_i] <= score;
          best_k[min_now_i] <= key_q;
        end
      end
      cts_pkg::ST_EMIT: begin
        if (emit_fire) oi <= oi + 1'b1;
      end
      default: begin
      end
    endcase

    // advance to the next entry once this one is ranked
    if (state_next == cts_pkg::ST_MAC &&
        (state == cts_pkg::ST_RANK || state == cts_pkg::ST_MIN)) begin
      ent  <= ent + 1'b1;
      base <= base + VA_W'(VECTOR_DIM);
      ci   <= '0;
      dot  <= '0;
      na   <= '0;
      nb   <= '0;
    end
    if (state_next == cts_pkg::ST_EMIT && state != cts_pkg::ST_EMIT) oi <= '0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      if (single) begin
        rsp.data.status         <= res_status;
        rsp.data.slot           <= 4'd0;
        rsp.data.match_key      <= skey;
        rsp.data.score          <= 16'sd0;
        rsp.data.end_of_results <= 1'b1;
      end else begin
        rsp.data.status         <= cts_pkg::STATUS_MATCH;
        rsp.data.slot           <= 4'(oi);
        rsp.data.match_key      <= best_k[KI_W'(oi)];
        rsp.data.score          <= best_s[KI_W'(oi)];
        rsp.data.end_of_results <= (oi == kq - 1'b1);
      end
    end
  end

endmodule
